// ===== rtl/ftwm_pkg.sv =====
package ftwm_pkg;

   localparam int FLOW_ENTRIES = 64;
   localparam int IDX_W = $clog2(FLOW_ENTRIES);
   localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int PROTO_W = 8;
   localparam int LEN_W = 16;
   localparam int TS_W = 64;
   localparam int KEY_W = 2 * ADDR_W;
   localparam int PP_W = 2 * PORT_W + PROTO_W;
   localparam int PKT_W = 32;
   localparam int BYTE_W = 64;
   localparam int SERIAL_W = 56;
   localparam int WIN_W = 31;

   // window divider: reciprocal estimate from the top timestamp bits, then fix-up
   localparam int TS_HI_W = 32;
   localparam int EST_W = TS_HI_W + WIN_W;
   localparam int ODD_W = 24;
   localparam int BACK_W = WIN_W + ODD_W;
   localparam int WINDOW_SHIFT = 10;
   localparam int REM_W = 35;
   localparam int DIV_STEPS = 4;
   localparam int DSTEP_W = 2;
   // floor(2^64 / 10^10)
   localparam logic [WIN_W-1:0] WINDOW_RECIP = WIN_W'(64'd1844674407);
   // 10^10 = 9765625 << 10
   localparam logic [ODD_W-1:0] WINDOW_ODD = ODD_W'(64'd9765625);
   localparam logic [REM_W-1:0] WINDOW_NS = REM_W'(64'd10000000000);
   localparam logic [REM_W-1:0] WINDOW_NS_X2 = REM_W'(64'd20000000000);

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [PP_W-1:0]     ports_proto;
      logic [PKT_W-1:0]    packet_count;
      logic [BYTE_W-1:0]   byte_count;
      logic [SERIAL_W-1:0] flow_serial;
      logic [WIN_W-1:0]    window_index;
   } entry_type;

   typedef struct packed {
      logic load;
      logic idx_inc;
      logic rd;
      logic wr_hit;
      logic wr_new;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic scan_end;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/ftwm_div.sv =====
module ftwm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ftwm_pkg::TS_W-1:0]       dividend,
   output logic [ftwm_pkg::WIN_W-1:0]      quotient,
   output logic                            done
);

   logic [ftwm_pkg::TS_W-1:0]    ts_ff, ts_in;
   logic [ftwm_pkg::WIN_W-1:0]   q0_ff, q0_in;
   logic [ftwm_pkg::BACK_W-1:0]  back_ff, back_in;
   logic [ftwm_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [ftwm_pkg::WIN_W-1:0]   q_ff, q_in;
   logic [ftwm_pkg::DSTEP_W-1:0] step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [ftwm_pkg::EST_W-1:0]   est;

   // estimate from the top timestamp bits is never above the quotient and at most two short
   assign est = ftwm_pkg::EST_W'(ts_ff[ftwm_pkg::TS_W-1:ftwm_pkg::TS_W-ftwm_pkg::TS_HI_W]) *
                ftwm_pkg::EST_W'(ftwm_pkg::WINDOW_RECIP);
   assign q0_in   = est[ftwm_pkg::EST_W-1:ftwm_pkg::TS_HI_W];
   assign back_in = ftwm_pkg::BACK_W'(q0_ff) * ftwm_pkg::BACK_W'(ftwm_pkg::WINDOW_ODD);
   assign rem_in  = ftwm_pkg::REM_W'(ts_ff -
                    {back_ff[ftwm_pkg::TS_W-ftwm_pkg::WINDOW_SHIFT-1:0],
                     {ftwm_pkg::WINDOW_SHIFT{1'b0}}});
   assign q_in    = q0_ff + ftwm_pkg::WIN_W'(rem_ff >= ftwm_pkg::WINDOW_NS) +
                    ftwm_pkg::WIN_W'(rem_ff >= ftwm_pkg::WINDOW_NS_X2);

   always_comb begin
      ts_in   = ts_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         ts_in   = dividend;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == ftwm_pkg::DSTEP_W'(ftwm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ts_ff   <= ts_in;
      q0_ff   <= q0_in;
      back_ff <= back_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/ftwm_datapath.sv =====
module ftwm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ftwm_pkg::ADDR_W-1:0]          req_source_address,
   input  logic [ftwm_pkg::ADDR_W-1:0]          req_destination_address,
   input  logic [ftwm_pkg::PORT_W-1:0]          req_source_port,
   input  logic [ftwm_pkg::PORT_W-1:0]          req_destination_port,
   input  logic [ftwm_pkg::PROTO_W-1:0]         req_protocol_number,
   input  logic [ftwm_pkg::LEN_W-1:0]           req_packet_length,
   input  logic [ftwm_pkg::TS_W-1:0]            req_timestamp_ns,
   input  logic                                 csr_write_enable,
   input  logic [ftwm_pkg::PKT_W-1:0]           csr_write_data,
   input  ftwm_pkg::cmd_type                    cmd,
   output ftwm_pkg::status_type                 status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_flow_hit,
   output logic                                 rsp_table_full,
   output logic [ftwm_pkg::SERIAL_W-1:0]        rsp_flow_number,
   output logic                                 rsp_report_valid,
   output logic [ftwm_pkg::WIN_W-1:0]           rsp_report_window,
   output logic [ftwm_pkg::PKT_W-1:0]           rsp_report_count
);

   ftwm_pkg::entry_type mem [ftwm_pkg::FLOW_ENTRIES];
   ftwm_pkg::entry_type rec_ff;
   ftwm_pkg::entry_type hit_rec, new_rec, wr_data;

   logic [ftwm_pkg::KEY_W-1:0]    key_ff;
   logic [ftwm_pkg::PP_W-1:0]     pp_ff;
   logic [ftwm_pkg::LEN_W-1:0]    len_ff;
   logic [ftwm_pkg::PKT_W-1:0]    limit_ff;
   logic [ftwm_pkg::CNT_W-1:0]    fill_ff;
   logic [ftwm_pkg::CNT_W-1:0]    idx_ff;
   logic [ftwm_pkg::SERIAL_W-1:0] serial_ff;
   logic                          rsp_valid_ff;
   logic                          hit_ff, full_ff, rvalid_ff;
   logic [ftwm_pkg::SERIAL_W-1:0] fnum_ff;
   logic [ftwm_pkg::WIN_W-1:0]    rwin_ff;
   logic [ftwm_pkg::PKT_W-1:0]    rcount_ff;

   logic [ftwm_pkg::WIN_W-1:0]    cur_win;
   logic                          div_done;
   logic                          table_full;
   logic                          grow, report;
   logic                          wr_en;
   logic [ftwm_pkg::IDX_W-1:0]    wr_addr;
   logic                          out_load;

   ftwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (req_timestamp_ns),
      .quotient (cur_win),
      .done     (div_done)
   );

   assign table_full = fill_ff == ftwm_pkg::CNT_W'(ftwm_pkg::FLOW_ENTRIES);
   assign grow   = rec_ff.packet_count < limit_ff;
   assign report = cur_win > rec_ff.window_index;

   always_comb begin
      hit_rec = rec_ff;
      if (grow) begin
         hit_rec.packet_count = rec_ff.packet_count + 1'b1;
         hit_rec.byte_count   = rec_ff.byte_count + ftwm_pkg::BYTE_W'(len_ff);
      end
      if (report) begin
         hit_rec.window_index = cur_win;
      end
   end

   always_comb begin
      new_rec.key          = key_ff;
      new_rec.ports_proto  = pp_ff;
      new_rec.packet_count = ftwm_pkg::PKT_W'(1);
      new_rec.byte_count   = ftwm_pkg::BYTE_W'(len_ff);
      new_rec.flow_serial  = serial_ff;
      new_rec.window_index = '0;
   end

   assign wr_en   = cmd.wr_hit || (cmd.wr_new && !table_full);
   assign wr_addr = cmd.wr_hit ? idx_ff[ftwm_pkg::IDX_W-1:0] : fill_ff[ftwm_pkg::IDX_W-1:0];
   assign wr_data = cmd.wr_hit ? hit_rec : new_rec;
   assign out_load = cmd.wr_hit || cmd.wr_new;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rec_ff <= mem[idx_ff[ftwm_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= {req_source_address, req_destination_address};
         pp_ff  <= {req_source_port, req_destination_port, req_protocol_number};
         len_ff <= req_packet_length;
      end
      if (out_load) begin
         hit_ff    <= cmd.wr_hit;
         full_ff   <= cmd.wr_new && table_full;
         fnum_ff   <= cmd.wr_hit ? rec_ff.flow_serial :
                      (table_full ? '0 : serial_ff);
         rvalid_ff <= cmd.wr_hit && report;
         rwin_ff   <= (cmd.wr_hit && report) ? rec_ff.window_index : '0;
         rcount_ff <= (cmd.wr_hit && report) ? hit_rec.packet_count : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '1;
         fill_ff      <= '0;
         idx_ff       <= '0;
         serial_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.wr_new) begin
            serial_ff <= serial_ff + 1'b1;
            if (!table_full) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.match    = (rec_ff.key == key_ff) && (rec_ff.ports_proto == pp_ff);
   assign status.scan_end = idx_ff == fill_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flow_hit      = hit_ff;
   assign rsp_table_full    = full_ff;
   assign rsp_flow_number   = fnum_ff;
   assign rsp_report_valid  = rvalid_ff;
   assign rsp_report_window = rwin_ff;
   assign rsp_report_count  = rcount_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= ftwm_pkg::CNT_W'(ftwm_pkg::FLOW_ENTRIES))
      else $error("fill count beyond table size");
   a_hit_div: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_hit |-> div_done)
      else $error("hit update before window index ready");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_hit && cmd.wr_new))
      else $error("hit and new entry write together");
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("result lost");

endmodule

// ===== rtl/ftwm_ctrl.sv =====
module ftwm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ftwm_pkg::status_type  status,
   output ftwm_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHK  = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_HIT  = 3'd3;
   localparam logic [2:0] ST_MISS = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (status.scan_end) begin
               state_in = ST_MISS;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (status.match) begin
               state_in = ST_HIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_CHK;
            end
         end
         ST_HIT: begin
            if (status.div_done && status.out_free) begin
               cmd.wr_hit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (status.out_free) begin
               cmd.wr_new = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_CHK)
      else $error("item taken but no scan started");
   a_hit_after_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HIT) |-> ($past(state_ff) == ST_CMP || $past(state_ff) == ST_HIT))
      else $error("hit state entered without compare");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd || cmd.wr_hit || cmd.wr_new) |-> req_stall)
      else $error("input open during lookup");

endmodule

// ===== rtl/flow_table_window_meter_unit.sv =====
// result: a miss scans every filled slot and a hit scans up to its slot and waits for the
//   window index divider; the result is registered and held while the output stalls
// throughput: one item at a time; the next item is taken the cycle after the table write
// table scan reads one entry per check and compare state pair from the entry memory
// reset (synchronous, active high) empties the table at once, clears the flow serial
//   and sets the count limit to all ones
module flow_table_window_meter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ftwm_pkg::ADDR_W-1:0]          req_source_address,
   input  logic [ftwm_pkg::ADDR_W-1:0]          req_destination_address,
   input  logic [ftwm_pkg::PORT_W-1:0]          req_source_port,
   input  logic [ftwm_pkg::PORT_W-1:0]          req_destination_port,
   input  logic [ftwm_pkg::PROTO_W-1:0]         req_protocol_number,
   input  logic [ftwm_pkg::LEN_W-1:0]           req_packet_length,
   input  logic [ftwm_pkg::TS_W-1:0]            req_timestamp_ns,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_flow_hit,
   output logic                                 rsp_table_full,
   output logic [ftwm_pkg::SERIAL_W-1:0]        rsp_flow_number,
   output logic                                 rsp_report_valid,
   output logic [ftwm_pkg::WIN_W-1:0]           rsp_report_window,
   output logic [ftwm_pkg::PKT_W-1:0]           rsp_report_count,
   input  logic                                 csr_write_enable,
   input  logic [ftwm_pkg::PKT_W-1:0]           csr_write_data
);

   ftwm_pkg::cmd_type    cmd;
   ftwm_pkg::status_type status;

   ftwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ftwm_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_source_address      (req_source_address),
      .req_destination_address (req_destination_address),
      .req_source_port         (req_source_port),
      .req_destination_port    (req_destination_port),
      .req_protocol_number     (req_protocol_number),
      .req_packet_length       (req_packet_length),
      .req_timestamp_ns        (req_timestamp_ns),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data),
      .cmd                     (cmd),
      .status                  (status),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_flow_hit            (rsp_flow_hit),
      .rsp_table_full          (rsp_table_full),
      .rsp_flow_number         (rsp_flow_number),
      .rsp_report_valid        (rsp_report_valid),
      .rsp_report_window       (rsp_report_window),
      .rsp_report_count        (rsp_report_count)
   );

endmodule

// ===== tb/sv/ftwm_flow_checker.sv =====
module ftwm_flow_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [ftwm_pkg::ADDR_W-1:0]   req_source_address,
   input  logic [ftwm_pkg::ADDR_W-1:0]   req_destination_address,
   input  logic [ftwm_pkg::PORT_W-1:0]   req_source_port,
   input  logic [ftwm_pkg::PORT_W-1:0]   req_destination_port,
   input  logic [ftwm_pkg::PROTO_W-1:0]  req_protocol_number,
   input  logic [ftwm_pkg::LEN_W-1:0]    req_packet_length,
   input  logic [ftwm_pkg::TS_W-1:0]     req_timestamp_ns,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_flow_hit,
   input  logic                          rsp_table_full,
   input  logic [ftwm_pkg::SERIAL_W-1:0] rsp_flow_number,
   input  logic                          rsp_report_valid,
   input  logic [ftwm_pkg::WIN_W-1:0]    rsp_report_window,
   input  logic [ftwm_pkg::PKT_W-1:0]    rsp_report_count,
   input  logic                          csr_write_enable,
   input  logic [ftwm_pkg::PKT_W-1:0]    csr_write_data,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ftwm_pkg::TS_W-1:0] NS_PER_WINDOW = 64'd10000000000;

   typedef struct {
      logic                          hit;
      logic                          full;
      logic [ftwm_pkg::SERIAL_W-1:0] flow_number;
      logic                          report_valid;
      logic [ftwm_pkg::WIN_W-1:0]    report_window;
      logic [ftwm_pkg::PKT_W-1:0]    report_count;
   } meter_result_type;

   logic [ftwm_pkg::PKT_W-1:0]    count_limit;
   logic                          slot_used [ftwm_pkg::FLOW_ENTRIES];
   logic [ftwm_pkg::KEY_W-1:0]    slot_key [ftwm_pkg::FLOW_ENTRIES];
   logic [ftwm_pkg::PP_W-1:0]     slot_pp [ftwm_pkg::FLOW_ENTRIES];
   logic [ftwm_pkg::PKT_W-1:0]    slot_packets [ftwm_pkg::FLOW_ENTRIES];
   logic [ftwm_pkg::BYTE_W-1:0]   slot_bytes [ftwm_pkg::FLOW_ENTRIES];
   logic [ftwm_pkg::SERIAL_W-1:0] slot_serial [ftwm_pkg::FLOW_ENTRIES];
   logic [ftwm_pkg::WIN_W-1:0]    slot_window [ftwm_pkg::FLOW_ENTRIES];
   logic [ftwm_pkg::SERIAL_W-1:0] serial_counter;
   meter_result_type              expected_results [$];

   assign pending = expected_results.size();

   function automatic meter_result_type meter_packet();
      meter_result_type           r;
      logic [ftwm_pkg::KEY_W-1:0] key;
      logic [ftwm_pkg::PP_W-1:0]  pp;
      logic [ftwm_pkg::WIN_W-1:0] cur;
      int                         match;
      int                         free_slot;
      key = {req_source_address, req_destination_address};
      pp = {req_source_port, req_destination_port, req_protocol_number};
      r = '{default: '0};
      match = -1;
      free_slot = -1;
      for (int i = 0; i < ftwm_pkg::FLOW_ENTRIES; i++) begin
         if (slot_used[i]) begin
            if (match < 0 && slot_key[i] == key && slot_pp[i] == pp) match = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (match >= 0) begin
         r.hit = 1'b1;
         if (slot_packets[match] < count_limit) begin
            slot_packets[match] = slot_packets[match] + 1'b1;
            slot_bytes[match] = slot_bytes[match] + req_packet_length;
         end
         cur = ftwm_pkg::WIN_W'(req_timestamp_ns / NS_PER_WINDOW);
         if (cur > slot_window[match]) begin
            r.report_valid = 1'b1;
            r.report_window = slot_window[match];
            r.report_count = slot_packets[match];
            slot_window[match] = cur;
         end
         r.flow_number = slot_serial[match];
      end else begin
         if (free_slot >= 0) begin
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_pp[free_slot] = pp;
            slot_packets[free_slot] = 1;
            slot_bytes[free_slot] = ftwm_pkg::BYTE_W'(req_packet_length);
            slot_serial[free_slot] = serial_counter;
            slot_window[free_slot] = '0;
            r.flow_number = serial_counter;
         end else begin
            r.full = 1'b1;
         end
         serial_counter = serial_counter + 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      meter_result_type e;
      if (reset) begin
         count_limit <= '1;
         serial_counter = '0;
         for (int i = 0; i < ftwm_pkg::FLOW_ENTRIES; i++) slot_used[i] = 1'b0;
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_enable) count_limit <= csr_write_data;
         if (req_valid && !req_stall) expected_results.push_back(meter_packet());
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got flow %h",
                        $time, rsp_flow_number);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (e.hit !== rsp_flow_hit || e.full !== rsp_table_full ||
                   e.flow_number !== rsp_flow_number ||
                   e.report_valid !== rsp_report_valid ||
                   e.report_window !== rsp_report_window ||
                   e.report_count !== rsp_report_count) begin
                  $display("%0t: mismatch expected hit %b full %b flow %h rep %b win %0d cnt %0d",
                           $time, e.hit, e.full, e.flow_number, e.report_valid,
                           e.report_window, e.report_count);
                  $display("%0t:          actual   hit %b full %b flow %h rep %b win %0d cnt %0d",
                           $time, rsp_flow_hit, rsp_table_full, rsp_flow_number,
                           rsp_report_valid, rsp_report_window, rsp_report_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   // leftover expectations are caught by the top waiting on pending
endmodule

// ===== tb/sv/tb_flow_table_window_meter_unit.sv =====
module tb_flow_table_window_meter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ftwm_pkg::TS_W-1:0] NS_PER_WINDOW = 64'd10000000000;
   localparam int POOL = 48;
   localparam int PHASE_ITEMS = 150;
   localparam int STALL_LIMIT = 20000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ftwm_pkg::ADDR_W-1:0]   req_source_address = '0;
   logic [ftwm_pkg::ADDR_W-1:0]   req_destination_address = '0;
   logic [ftwm_pkg::PORT_W-1:0]   req_source_port = '0;
   logic [ftwm_pkg::PORT_W-1:0]   req_destination_port = '0;
   logic [ftwm_pkg::PROTO_W-1:0]  req_protocol_number = '0;
   logic [ftwm_pkg::LEN_W-1:0]    req_packet_length = '0;
   logic [ftwm_pkg::TS_W-1:0]     req_timestamp_ns = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_flow_hit;
   logic                          rsp_table_full;
   logic [ftwm_pkg::SERIAL_W-1:0] rsp_flow_number;
   logic                          rsp_report_valid;
   logic [ftwm_pkg::WIN_W-1:0]    rsp_report_window;
   logic [ftwm_pkg::PKT_W-1:0]    rsp_report_count;
   logic                          csr_write_enable = 1'b0;
   logic [ftwm_pkg::PKT_W-1:0]    csr_write_data = '0;
   int                            fail_count;
   int                            pending;

   int                            send_idle_pct = 0;
   int                            stall_pct = 0;
   int                            quiet_cycles = 0;

   logic [ftwm_pkg::ADDR_W-1:0]   pool_src [POOL];
   logic [ftwm_pkg::ADDR_W-1:0]   pool_dst [POOL];
   logic [ftwm_pkg::PORT_W-1:0]   pool_sport [POOL];
   logic [ftwm_pkg::PORT_W-1:0]   pool_dport [POOL];
   logic [ftwm_pkg::PROTO_W-1:0]  pool_proto [POOL];

   always #5 clock = ~clock;

   flow_table_window_meter_unit dut (.*);

   ftwm_flow_checker checker_i (.*);

   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_packet(input logic [ftwm_pkg::ADDR_W-1:0] src,
                              input logic [ftwm_pkg::ADDR_W-1:0] dst,
                              input logic [ftwm_pkg::PORT_W-1:0] sport,
                              input logic [ftwm_pkg::PORT_W-1:0] dport,
                              input logic [ftwm_pkg::PROTO_W-1:0] proto,
                              input logic [ftwm_pkg::LEN_W-1:0] len,
                              input logic [ftwm_pkg::TS_W-1:0] ts);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_address <= src;
      req_destination_address <= dst;
      req_source_port <= sport;
      req_destination_port <= dport;
      req_protocol_number <= proto;
      req_packet_length <= len;
      req_timestamp_ns <= ts;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_count_limit(input logic [ftwm_pkg::PKT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [ftwm_pkg::TS_W-1:0] random_ts(
         input logic [ftwm_pkg::TS_W-1:0] win);
      logic [ftwm_pkg::TS_W-1:0] offset;
      offset = {$urandom, $urandom} % NS_PER_WINDOW;
      return win * NS_PER_WINDOW + offset;
   endfunction

   initial begin
      logic [ftwm_pkg::TS_W-1:0] now_win;
      logic [ftwm_pkg::TS_W-1:0] ts;
      logic [ftwm_pkg::PKT_W-1:0] limits [6];
      int k;
      limits = '{32'hFFFF_FFFF, 32'd1, 32'd3, 32'd0, 32'd0, 32'hFFFF_FFFF};
      limits[4] = $urandom_range(2, 12);
      for (int i = 0; i < POOL; i++) begin
         pool_src[i] = $urandom;
         pool_dst[i] = $urandom;
         pool_proto[i] = ftwm_pkg::PROTO_W'($urandom);
         pool_sport[i] = (i % 8 == 0) ? '0 : ftwm_pkg::PORT_W'($urandom);
         pool_dport[i] = (i % 8 == 0) ? '0 : ftwm_pkg::PORT_W'($urandom);
         if (i % 8 == 0) pool_proto[i] = 8'd1;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // new flow, hit in same window, window advance, older window, top timestamp
      send_packet('0, '0, '0, '0, '0, '0, '0);
      send_packet('0, '0, '0, '0, '0, 16'hFFFF, 64'd9999999999);
      send_packet('0, '0, '0, '0, '0, 16'd1, NS_PER_WINDOW);
      send_packet('0, '0, '0, '0, '0, 16'd2, 64'd5);
      send_packet('0, '0, '0, '0, '0, 16'd3, 64'hFFFF_FFFF_FFFF_FFFF);
      send_packet('1, '1, '1, '1, '1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_packet('1, '1, '1, '1, '1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // tuples differing in one field only
      send_packet('1, '1, '1, '1, 8'hFE, 16'd64, 64'd0);
      send_packet('1, '1, '1, 16'hFFFE, '1, 16'd64, 64'd0);
      send_packet('1, '1, 16'hFFFE, '1, '1, 16'd64, 64'd0);
      send_packet('1, 32'hFFFF_FFFE, '1, '1, '1, 16'd64, 64'd0);
      send_packet(32'hFFFF_FFFE, '1, '1, '1, '1, 16'd64, 64'd0);
      send_packet(32'h0A00_0001, 32'h0A00_0002, '0, '0, 8'd1, 16'd84, NS_PER_WINDOW * 3);
      send_packet(32'h0A00_0001, 32'h0A00_0002, '0, '0, 8'd1, 16'd84, NS_PER_WINDOW * 5);
      send_packet(32'h0A00_0001, 32'h0A00_0002, '0, '0, 8'd1, 16'd84, NS_PER_WINDOW * 5);

      now_win = 1;
      for (int p = 0; p < 6; p++) begin
         write_count_limit(limits[p]);
         case (p % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 57; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 57; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 7) == 0) now_win = now_win + 1;
            ts = random_ts(now_win - $urandom_range(0, 1));
            if ($urandom_range(0, 99) < 85) begin
               k = $urandom_range(0, POOL - 1);
               if ($urandom_range(0, 99) < 3) ts = {$urandom, $urandom};
               send_packet(pool_src[k], pool_dst[k], pool_sport[k], pool_dport[k],
                           pool_proto[k], ftwm_pkg::LEN_W'($urandom), ts);
            end else begin
               send_packet($urandom, $urandom, ftwm_pkg::PORT_W'($urandom),
                           ftwm_pkg::PORT_W'($urandom), ftwm_pkg::PROTO_W'($urandom),
                           ftwm_pkg::LEN_W'($urandom), {$urandom, $urandom});
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/ftwm_pkg.sv
rtl/ftwm_div.sv
rtl/ftwm_datapath.sv
rtl/ftwm_ctrl.sv
rtl/flow_table_window_meter_unit.sv
tb/sv/ftwm_flow_checker.sv
tb/sv/tb_flow_table_window_meter_unit.sv
